### sv/maf_pkg.sv
// Shared constants and state types for the moving average filter.
package maf_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int WL_W           = 6;
  localparam int MAX_WINDOW_DEF = 32;
  localparam logic [WL_W-1:0] WINDOW_RESET = 6'd20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_LOAD
  } ctl_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_ABS,
    DIV_RUN,
    DIV_SIGN
  } div_state_t;

endpackage

### sv/maf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module maf_ram
  import maf_pkg::*;
#(
  parameter int WIDTH = SAMPLE_W,
  parameter int DEPTH = MAX_WINDOW_DEF,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### sv/maf_divider.sv
// Bit-serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module maf_divider
  import maf_pkg::*;
#(
  parameter int SUM_W = 38,
  parameter int CNT_W = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SUM_W-1:0]    dividend,
  input  logic [CNT_W-1:0]    divisor,
  output logic                done_r,
  output logic [SAMPLE_W-1:0] quo_r
);

  localparam int StepW = $clog2(SUM_W + 1);
  localparam logic [StepW-1:0] STEPS = StepW'(SUM_W);
  localparam logic [StepW-1:0] ONE   = StepW'(1);

  div_state_t        state_r, state_nxt;
  logic [SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dsr_r, dsr_nxt;
  logic              neg_r, neg_nxt;
  logic [StepW-1:0]  cnt_r, cnt_nxt;
  logic              done_nxt;
  logic [SAMPLE_W-1:0] quo_nxt;
  logic [CNT_W:0]    partial;
  logic [CNT_W:0]    diff;
  logic              ge;

  // one restoring step: bring down the next dividend bit and trial-subtract
  assign partial = {rem_r, dvd_r[SUM_W-1]};
  assign ge      = (partial >= {1'b0, dsr_r});
  assign diff    = partial - {1'b0, dsr_r};

  always_comb begin
    state_nxt = state_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    dsr_nxt   = dsr_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    quo_nxt   = quo_r;
    case (state_r)
      DIV_IDLE: begin
        if (start) begin
          dvd_nxt   = dividend;
          dsr_nxt   = divisor;
          state_nxt = DIV_ABS;
        end
      end
      DIV_ABS: begin
        // take the magnitude, remember the sign
        neg_nxt   = dvd_r[SUM_W-1];
        dvd_nxt   = dvd_r[SUM_W-1] ? (~dvd_r + SUM_W'(1)) : dvd_r;
        rem_nxt   = '0;
        cnt_nxt   = STEPS;
        state_nxt = DIV_RUN;
      end
      DIV_RUN: begin
        rem_nxt = ge ? diff[CNT_W-1:0] : partial[CNT_W-1:0];
        dvd_nxt = {dvd_r[SUM_W-2:0], ge};
        cnt_nxt = cnt_r - ONE;
        if (cnt_r == ONE) begin
          state_nxt = DIV_SIGN;
        end
      end
      DIV_SIGN: begin
        // restore the sign of the quotient
        quo_nxt   = neg_r ? (~dvd_r[SAMPLE_W-1:0] + SAMPLE_W'(1)) : dvd_r[SAMPLE_W-1:0];
        done_nxt  = 1'b1;
        state_nxt = DIV_IDLE;
      end
      default: begin
        state_nxt = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
  end

endmodule

### sv/moving_average_filter.sv
// Each accepted sample is read from the store, added into the 38-bit running sum (depth 32) and divided.
// The next sample is accepted only once the previous mean is in the result register; the
// bit-serial divider, resolving one quotient bit of the running sum per cycle, sets the pace.
// The result register frees the input side while a finished beat waits downstream.
// Reset (rst_n low, synchronous): window length 20, sum, write position and fill count
// cleared; stored samples are ignored until rewritten, so no clearing pass is needed.
module moving_average_filter
  import maf_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_average,
  output logic                       out_window_full,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [WL_W-1:0]            cfg_window_length
);

  localparam int AddrW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CntW  = $clog2(MAX_WINDOW + 1);
  localparam int SumW  = SAMPLE_W + $clog2(MAX_WINDOW) + 1;
  localparam logic [CntW-1:0] CNT_ONE = CntW'(1);
  localparam logic [CntW-1:0] CNT_MAX = CntW'(MAX_WINDOW);

  ctl_state_t            state_r, state_nxt;
  logic [WL_W-1:0]       wl_r, wl_nxt;
  logic [SumW-1:0]       sum_r, sum_nxt;
  logic [AddrW-1:0]      wp_r, wp_nxt;
  logic [CntW-1:0]       fill_r, fill_nxt;
  logic [SAMPLE_W-1:0]   smp_r, smp_nxt;
  logic                  full_r, full_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]   avg_r, avg_nxt;
  logic                  wfull_r, wfull_nxt;

  logic [CntW-1:0]       win;
  logic [CntW-1:0]       wp_ext;
  logic [AddrW-1:0]      wp_eff;
  logic [CntW-1:0]       wp_inc;
  logic [SAMPLE_W-1:0]   old_smp;
  logic [SAMPLE_W-1:0]   ram_rdata;
  logic                  ram_re;
  logic                  ram_we;
  logic                  div_start;
  logic                  div_done;
  logic [SAMPLE_W-1:0]   div_quo;
  logic                  in_fire;
  logic                  cfg_fire;
  logic                  out_free;

  // clamp the window length to 1 .. MAX_WINDOW
  always_comb begin
    if (wl_r == '0) begin
      win = CNT_ONE;
    end else if (32'(wl_r) > 32'(MAX_WINDOW)) begin
      win = CNT_MAX;
    end else begin
      win = CntW'(wl_r);
    end
  end

  assign wp_ext  = CntW'(wp_r);
  assign wp_eff  = (wp_ext >= win) ? '0 : wp_r;
  assign wp_inc  = CntW'(wp_r) + CNT_ONE;
  // an entry not yet written since the last clear reads as zero
  assign old_smp = (wp_ext < fill_r) ? ram_rdata : '0;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // sequence one sample: read old entry, update sum, divide, hand over
  always_comb begin
    state_nxt     = state_r;
    wl_nxt        = wl_r;
    sum_nxt       = sum_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    smp_nxt       = smp_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r;
    avg_nxt       = avg_r;
    wfull_nxt     = wfull_r;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    div_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          smp_nxt   = in_sample;
          wp_nxt    = wp_eff;
          ram_re    = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        ram_we    = 1'b1;
        div_start = 1'b1;
        sum_nxt   = sum_r - {{(SumW-SAMPLE_W){old_smp[SAMPLE_W-1]}}, old_smp}
                          + {{(SumW-SAMPLE_W){smp_r[SAMPLE_W-1]}}, smp_r};
        wp_nxt    = (wp_inc >= win) ? '0 : wp_inc[AddrW-1:0];
        fill_nxt  = (fill_r < win) ? (fill_r + CNT_ONE) : fill_r;
        full_nxt  = (fill_nxt >= win);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          avg_nxt       = div_quo;
          wfull_nxt     = full_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // a window write restarts the averaging
    if (cfg_fire) begin
      wl_nxt   = cfg_window_length;
      sum_nxt  = '0;
      wp_nxt   = '0;
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wl_r        <= WINDOW_RESET;
      sum_r       <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wl_r        <= wl_nxt;
      sum_r       <= sum_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    smp_r   <= smp_nxt;
    full_r  <= full_nxt;
    avg_r   <= avg_nxt;
    wfull_r <= wfull_nxt;
  end

  maf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (wp_r),
    .wdata   (smp_r),
    .re      (ram_re),
    .raddr   (wp_eff),
    .rdata_r (ram_rdata)
  );

  maf_divider #(
    .SUM_W (SumW),
    .CNT_W (CntW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (fill_nxt),
    .done_r   (div_done),
    .quo_r    (div_quo)
  );

  assign out_valid       = out_valid_r;
  assign out_average     = avg_r;
  assign out_window_full = wfull_r;

endmodule

### tb/tb_top.sv
// Self-checking testbench for the boxcar moving average filter.
`timescale 1ns / 1ps

module tb_top;
  import maf_pkg::*;

  localparam int DEPTH       = MAX_WINDOW_DEF;
  localparam int CLK_HALF    = 6;
  localparam int RAND_ITEMS  = 1850;
  localparam int TAIL_CYCLES = 60;
  localparam int CYCLE_LIMIT = 1200000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] average;
    logic                       window_full;
  } mean_t;

  typedef enum logic {ROW_CFG, ROW_SMP} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [WL_W-1:0]            wl;
    logic signed [SAMPLE_W-1:0] smp;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] avg;
    logic                       full;
  } dir_row_t;

  localparam int DIR_N = 23;

  // Directed rows: expected results typed in only where they are obvious
  dir_row_t dir_tab [DIR_N] = '{
    // reset window of 20: first mean is the sample itself
    '{ROW_SMP, 6'd0, 32'sd100,      1'b1, 32'sd100,      1'b0},
    '{ROW_SMP, 6'd0, 32'h7FFFFFFF,  1'b0, 32'sd0,        1'b0},
    '{ROW_SMP, 6'd0, 32'h80000000,  1'b0, 32'sd0,        1'b0},
    '{ROW_SMP, 6'd0, -32'sd7,       1'b0, 32'sd0,        1'b0},
    // window of one passes samples straight through
    '{ROW_CFG, 6'd1, 32'sd0,        1'b0, 32'sd0,        1'b0},
    '{ROW_SMP, 6'd0, 32'h7FFFFFFF,  1'b1, 32'h7FFFFFFF,  1'b1},
    '{ROW_SMP, 6'd0, 32'h80000000,  1'b1, 32'h80000000,  1'b1},
    '{ROW_SMP, 6'd0, -32'sd1,       1'b1, -32'sd1,       1'b1},
    '{ROW_SMP, 6'd0, 32'sd0,        1'b1, 32'sd0,        1'b1},
    // window of zero behaves as one
    '{ROW_CFG, 6'd0, 32'sd0,        1'b0, 32'sd0,        1'b0},
    '{ROW_SMP, 6'd0, 32'sd12345,    1'b1, 32'sd12345,    1'b1},
    '{ROW_SMP, 6'd0, -32'sd5,       1'b1, -32'sd5,       1'b1},
    // window of two: -1/2 truncates toward zero
    '{ROW_CFG, 6'd2, 32'sd0,        1'b0, 32'sd0,        1'b0},
    '{ROW_SMP, 6'd0, 32'sd7,        1'b1, 32'sd7,        1'b0},
    '{ROW_SMP, 6'd0, -32'sd8,       1'b1, 32'sd0,        1'b1},
    '{ROW_SMP, 6'd0, -32'sd8,       1'b1, -32'sd8,       1'b1},
    // window above the store depth saturates
    '{ROW_CFG, 6'd63, 32'sd0,       1'b0, 32'sd0,        1'b0},
    '{ROW_SMP, 6'd0, 32'h7FFFFFFF,  1'b0, 32'sd0,        1'b0},
    '{ROW_SMP, 6'd0, 32'h7FFFFFFF,  1'b0, 32'sd0,        1'b0},
    '{ROW_SMP, 6'd0, 32'h80000000,  1'b0, 32'sd0,        1'b0},
    // full depth with the most negative sample
    '{ROW_CFG, 6'd32, 32'sd0,       1'b0, 32'sd0,        1'b0},
    '{ROW_SMP, 6'd0, 32'h80000000,  1'b1, 32'h80000000,  1'b0},
    '{ROW_SMP, 6'd0, 32'h80000000,  1'b1, 32'h80000000,  1'b0}
  };

  logic                       clk               = 1'b0;
  logic                       rst_n             = 1'b0;
  logic                       in_valid          = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample         = '0;
  logic                       out_valid;
  logic                       out_ready         = 1'b0;
  logic signed [SAMPLE_W-1:0] out_average;
  logic                       out_window_full;
  logic                       cfg_valid         = 1'b0;
  logic                       cfg_ready;
  logic [WL_W-1:0]            cfg_window_length = WINDOW_RESET;

  // Predictor state
  logic [WL_W-1:0] win_len = WINDOW_RESET;
  longint          ring [DEPTH];
  longint          ring_sum = 0;
  int              wr_pos   = 0;
  int              fill_cnt = 0;

  mean_t mean_q [$];
  mean_t want;
  int    n_err     = 0;
  int    cycles    = 0;
  int    stall_left = 0;
  int    calm_left  = 0;
  int    roll;

  moving_average_filter u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_average       (out_average),
    .out_window_full   (out_window_full),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_length (cfg_window_length)
  );

  always #(CLK_HALF) clk = ~clk;

  // Clamp the programmed length to 1..DEPTH
  function automatic int eff_window();
    if (win_len == 0) return 1;
    if (win_len > DEPTH) return DEPTH;
    return int'(win_len);
  endfunction

  function automatic void clear_window(input logic [WL_W-1:0] w);
    win_len = w;
    for (int i = 0; i < DEPTH; i++) ring[i] = 0;
    ring_sum = 0;
    wr_pos   = 0;
    fill_cnt = 0;
  endfunction

  // Replace the oldest sample, update the sum and divide by the fill count
  function automatic mean_t boxcar_mean(input logic signed [SAMPLE_W-1:0] smp);
    int     win;
    longint s;
    longint q;
    mean_t  r;
    win = eff_window();
    s   = smp;
    if (wr_pos >= win) wr_pos = 0;
    ring_sum     = ring_sum - ring[wr_pos] + s;
    ring[wr_pos] = s;
    wr_pos++;
    if (wr_pos >= win) wr_pos = 0;
    if (fill_cnt < win) fill_cnt++;
    q = ring_sum / fill_cnt;
    r.average     = q[SAMPLE_W-1:0];
    r.window_full = (fill_cnt >= win);
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      5, 6:    return $signed($urandom_range(0, 200)) - 100;
      7: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7FFFFFFF;
          1:       return 32'h80000000;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      8:       return 32'h7FFFFFFF - $urandom_range(0, 1000);
      9:       return 32'h80000000 + $urandom_range(0, 1000);
      default: return $urandom;
    endcase
  endfunction

  // Present one beat, hold it until accepted, then record its mean
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic typed,
                             input mean_t typed_val);
    mean_t pred;
    in_valid  <= 1'b1;
    in_sample <= smp;
    do @(posedge clk); while (!in_ready);
    pred = boxcar_mean(smp);
    mean_q.push_back(typed ? typed_val : pred);
  endtask

  task automatic drain();
    while (mean_q.size() != 0) @(posedge clk);
  endtask

  // Program the window once every pending result is out
  task automatic write_window(input logic [WL_W-1:0] w);
    in_valid <= 1'b0;
    drain();
    cfg_valid         <= 1'b1;
    cfg_window_length <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    clear_window(w);
  endtask

  // Receiver: random stalls, with occasional calm stretches
  always @(posedge clk) begin
    if (calm_left > 0) begin
      calm_left--;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 3) calm_left = $urandom_range(100, 600);
      else if (roll < 25) stall_left = $urandom_range(1, 60);
    end
  end

  // Compare each result beat with the oldest expected mean
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (mean_q.size() == 0) begin
        $error("unexpected result beat: average %0d window_full %0b",
               out_average, out_window_full);
        n_err++;
      end else begin
        want = mean_q.pop_front();
        if (out_average !== want.average) begin
          $error("average: expected %0d, got %0d", want.average, out_average);
          n_err++;
        end
        if (out_window_full !== want.window_full) begin
          $error("window_full: expected %0b, got %0b", want.window_full, out_window_full);
          n_err++;
        end
      end
    end
  end

  // Hard stop on a hang
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    mean_t           tv;
    logic [WL_W-1:0] w;
    int              n_sent;
    int              ph;
    int              ph_len;
    int              burst_left;
    int              gap;

    clear_window(WINDOW_RESET);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (int i = 0; i < DIR_N; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_window(dir_tab[i].wl);
      end else begin
        tv.average     = dir_tab[i].avg;
        tv.window_full = dir_tab[i].full;
        send_sample(dir_tab[i].smp, dir_tab[i].typed, tv);
      end
    end

    // Random phases: extremes of the window first, then random lengths
    n_sent = 0;
    ph     = 0;
    while (n_sent < RAND_ITEMS) begin
      case (ph)
        0:       w = WL_W'(DEPTH);
        1:       w = '1;
        2:       w = 6'd1;
        3:       w = 6'd0;
        default: w = WL_W'($urandom_range(0, 63));
      endcase
      write_window(w);
      ph++;
      ph_len     = $urandom_range(15, 110);
      burst_left = $urandom_range(1, 25);
      for (int k = 0; k < ph_len && n_sent < RAND_ITEMS; k++) begin
        send_sample(pick_sample(), 1'b0, '0);
        n_sent++;
        burst_left--;
        if ($urandom_range(0, 149) == 0) begin
          // hold off until the pipeline is empty
          in_valid <= 1'b0;
          drain();
        end else if (burst_left <= 0) begin
          in_valid <= 1'b0;
          gap = $urandom_range(1, 60);
          repeat (gap) @(posedge clk);
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                    : $urandom_range(1, 25);
        end
      end
    end

    in_valid <= 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
